// ===== hdl/arenv_pkg.sv =====
// arenv_pkg: widths, register indexes and the controller command struct
// shared by the attack/release envelope follower modules.
// no dependencies.
package arenv_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int ENV_W      = 17;
   localparam int COEF_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = COEF_W + 1;
   localparam int MUL_B_W = ENV_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(65536);

   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_COEF  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_COEF = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_DETECT_MODE  = CSR_IDX_W'(2);

   localparam logic DETECT_PEAK   = 1'b0;
   localparam logic DETECT_SQUARE = 1'b1;

   typedef struct packed {
      logic load;     // capture magnitude of the accepted sample
      logic square;   // multiplier: magnitude squared
      logic level;    // form level, pick coefficient, form difference
      logic product;  // multiplier: coefficient times difference
      logic update;   // form, clamp and store the new envelope
   } dp_cmd_type;

endpackage

// ===== hdl/arenv_if.sv =====
// arenv_if: valid/ready channel interfaces for the sample input and the
// envelope result. depends on arenv_pkg.
interface arenv_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [arenv_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface arenv_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [arenv_pkg::ENV_W-1:0]  envelope_out;

   modport source (output valid, output envelope_out, input ready);
   modport sink   (input valid, input envelope_out, output ready);
endinterface

// ===== hdl/arenv_datapath.sv =====
// arenv_datapath: configuration registers, envelope state and the shared
// multiplier of the envelope follower. depends on arenv_pkg.
module arenv_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [arenv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [arenv_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  arenv_pkg::dp_cmd_type                 cmd,
   input  logic signed [arenv_pkg::SAMPLE_W-1:0] sample,
   output logic [arenv_pkg::ENV_W-1:0]           envelope_out
);

   localparam int SW = arenv_pkg::SAMPLE_W;
   localparam int EW = arenv_pkg::ENV_W;
   localparam int CW = arenv_pkg::COEF_W;
   localparam int AW = arenv_pkg::MUL_A_W;
   localparam int BW = arenv_pkg::MUL_B_W;
   localparam int PW = arenv_pkg::PROD_W;
   localparam int SHW = PW - 16;   // product after the >>16
   localparam int SUMW = SHW + 1;

   logic [CW-1:0]        attack_ff;
   logic [CW-1:0]        release_ff;
   logic                 mode_ff;
   logic [EW-1:0]        env_ff, env_in;
   logic [SW-1:0]        mag_ff, mag_in;
   logic signed [PW-1:0] prod_ff;
   logic [EW-1:0]        level_ff, level_in;
   logic [CW-1:0]        coef_ff, coef_in;
   logic signed [BW-1:0] diff_ff, diff_in;

   logic signed [AW-1:0]   mul_a;
   logic signed [BW-1:0]   mul_b;
   logic signed [SHW-1:0]  shifted;
   logic signed [SUMW-1:0] sum;

   // configuration writes, out-of-range index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= '0;
         release_ff <= '0;
         mode_ff    <= arenv_pkg::DETECT_PEAK;
      end else if (csr_we) begin
         case (csr_index)
            arenv_pkg::CSR_ATTACK_COEF:  attack_ff  <= csr_wdata[CW-1:0];
            arenv_pkg::CSR_RELEASE_COEF: release_ff <= csr_wdata[CW-1:0];
            arenv_pkg::CSR_DETECT_MODE:  mode_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // magnitude; -32768 gives 32768, which still fits unsigned
   always_comb begin
      mag_in = sample[SW-1] ? SW'(-sample) : SW'(sample);
   end

   always_comb begin
      if (mode_ff == arenv_pkg::DETECT_SQUARE) begin
         level_in = prod_ff[EW+13:14];
      end else begin
         level_in = {mag_ff, 1'b0};
      end
      coef_in = (level_in > env_ff) ? attack_ff : release_ff;
      diff_in = $signed({1'b0, env_ff}) - $signed({1'b0, level_in});
   end

   // one multiplier, shared between the square and the coefficient product
   always_comb begin
      if (cmd.product) begin
         mul_a = $signed({1'b0, coef_ff});
         mul_b = diff_ff;
      end else begin
         mul_a = $signed(AW'(mag_ff));
         mul_b = $signed(BW'(mag_ff));
      end
   end

   always_comb begin
      shifted = prod_ff[PW-1:16];
      sum     = SUMW'(shifted) + $signed(SUMW'(level_ff));
      if (sum < 0) begin
         env_in = '0;
      end else if (sum > $signed(SUMW'(arenv_pkg::ENV_ONE))) begin
         env_in = arenv_pkg::ENV_ONE;
      end else begin
         env_in = sum[EW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff <= '0;
      end else if (cmd.update) begin
         env_ff <= env_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff <= mag_in;
      end
      if (cmd.square || cmd.product) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.level) begin
         level_ff <= level_in;
         coef_ff  <= coef_in;
         diff_ff  <= diff_in;
      end
   end

   // envelope only changes when a new result is loaded, so it is the payload
   assign envelope_out = env_ff;

endmodule

// ===== hdl/arenv_ctrl.sv =====
// arenv_ctrl: sequencer for the envelope follower; handles both handshakes
// and issues datapath commands. depends on arenv_pkg.
module arenv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output arenv_pkg::dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_LEVEL,
      ST_PRODUCT,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      accept;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_UPDATE: req_ready = slot_free;
         default:   req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.load     = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_LEVEL;
         end
         ST_LEVEL: begin
            cmd.level = 1'b1;
            state_in  = ST_PRODUCT;
         end
         ST_PRODUCT: begin
            cmd.product = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the result register can take the new envelope
            if (slot_free) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = accept ? ST_SQUARE : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/attack_release_envelope_follower.sv =====
// Attack/release envelope follower, one pole, fixed point.
// Input channel req_chan carries one signed Q1.15 sample per item; result
// channel rsp_chan returns one unsigned Q1.16 envelope (65536 = 1.0) per item.
// Coefficients (Q0.16) and the detect mode are written on the csr_ port:
// index 0 attack, 1 release, 2 detect mode (0 peak, 1 squared); others ignored.
// Each item goes through four steps on one shared multiplier: square,
// level/compare, coefficient product, update. The result is registered
// in the update step; the next item is accepted in the update step when the
// receiver keeps up, so a new item can enter before the last is out.
// Results sit in an output register; a stalled receiver holds the block in
// its update step while one result waits, so nothing is lost or reordered.
// Reset (synchronous) clears the envelope, the configuration registers and
// the result valid; the block can take an item in the cycle after reset drops.
// Depends on arenv_pkg, arenv_if, arenv_ctrl and arenv_datapath.
module attack_release_envelope_follower (
   input  logic                               clock,
   input  logic                               reset,
   arenv_req_if.sink                          req_chan,
   arenv_rsp_if.source                        rsp_chan,
   input  logic                               csr_we,
   input  logic [arenv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [arenv_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   arenv_pkg::dp_cmd_type cmd;

   arenv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   arenv_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .sample       (req_chan.sample),
      .envelope_out (rsp_chan.envelope_out)
   );

endmodule
